>>> hdl/i2cm_pkg.sv
// shared types and constants for the i2c master register block
`default_nettype none
package i2cm_pkg;
   localparam int REPLY_ENTRIES = 256;
   localparam int REG_SPACE = 32;
   localparam int ReplyAw = (REPLY_ENTRIES > 1) ? $clog2(REPLY_ENTRIES) : 1;
   localparam int RegAw = $clog2(REG_SPACE);

   localparam logic [1:0] CMD_READ = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_TICK = 2'd2;
   localparam logic [1:0] CMD_LOAD = 2'd3;

   localparam logic [2:0] CSR_SLAVE_ENABLE = 3'd0;
   localparam logic [2:0] CSR_NAK_UNANSWERED = 3'd1;
   localparam logic [2:0] CSR_STUCK_DROP = 3'd2;
   localparam logic [2:0] CSR_BYTE_TICKS = 3'd3;
   localparam logic [2:0] CSR_STUCK_TICKS = 3'd4;
   localparam logic [2:0] CSR_MASK_LOW = 3'd5;
   localparam logic [2:0] CSR_MASK_HIGH = 3'd6;

   localparam logic [4:0] OFF_DR = 5'd0;
   localparam logic [4:0] OFF_CR = 5'd4;
   localparam logic [4:0] OFF_SR = 5'd8;
   localparam logic [4:0] OFF_IC = 5'd12;

   localparam logic [7:0] SR_FIXED = 8'hC0;
   localparam logic [7:0] IC_MASK = 8'h0F;
   localparam logic [7:0] BYTE_ONES = 8'hFF;
   localparam logic [6:0] ADDR7_MASK = 7'h7F;
   localparam int MUTE_CAP_SHIFT = 6;

   typedef struct packed {
      logic [1:0] cmd;
      logic [4:0] reg_offset;
      logic [7:0] write_data;
      logic [7:0] reply_index;
      logic [7:0] reply_value;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_arb_lost;
      logic       irq_tack;
      logic       irq_wait;
      logic       irq_dte;
   } rsp_type;

   typedef struct packed {
      logic        slave_enable;
      logic        nak_unanswered;
      logic        stuck_drop;
      logic [15:0] byte_ticks;
      logic [19:0] stuck_ticks;
      logic [63:0] mask_low;
      logic [63:0] mask_high;
   } cfg_type;

   typedef struct packed {
      logic       load;
      logic [7:0] index;
      logic [7:0] value;
   } load_type;
endpackage
`default_nettype wire

>>> hdl/i2c_master_with_answering_slaves.sv
// top level: handshake, settings registers, reply table and bus core
//
// req channel carries one beat per host operation: a register read, a
// register write, one time tick or a reply table load. every request beat
// yields exactly one rsp beat with the read data and the four interrupt
// levels as they stand after that operation.
// a request's response is registered and shows in the cycle after it is
// accepted. throughput is one beat per cycle while the receiver keeps up,
// set by the single output register; req_ready stays high while that
// register is empty or drained. when the receiver stalls, the response
// holds in the output register and req_ready drops until it is taken.
// csr_write writes a setting at csr_index in the same cycle; the user must
// change settings only while no beat is in flight, which the block does not
// enforce. synchronous reset clears the bus state, the registers, the reply
// table and the settings to their defaults; no clearing pass.
`default_nettype none
module i2c_master_with_answering_slaves (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire i2cm_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output i2cm_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write,
   input  wire logic [2:0]        csr_index,
   input  wire logic [63:0]       csr_wdata
);
   import i2cm_pkg::*;

   cfg_type  cfg_ff;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_data_ff;
   rsp_type  core_rsp;
   logic     beat;
   logic [7:0] next_cmd_byte;
   logic [7:0] reply_cur;
   load_type load;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign beat = req_valid && req_ready;
   assign load.load = beat && req_data.cmd == CMD_LOAD;
   assign load.index = req_data.reply_index;
   assign load.value = req_data.reply_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slave_enable <= 1'b0;
         cfg_ff.nak_unanswered <= 1'b0;
         cfg_ff.stuck_drop <= 1'b0;
         cfg_ff.byte_ticks <= 16'd90;
         cfg_ff.stuck_ticks <= 20'd50000;
         cfg_ff.mask_low <= 64'd281474976710656;
         cfg_ff.mask_high <= 64'd0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SLAVE_ENABLE: cfg_ff.slave_enable <= csr_wdata[0];
            CSR_NAK_UNANSWERED: cfg_ff.nak_unanswered <= csr_wdata[0];
            CSR_STUCK_DROP: cfg_ff.stuck_drop <= csr_wdata[0];
            CSR_BYTE_TICKS: cfg_ff.byte_ticks <= csr_wdata[15:0];
            CSR_STUCK_TICKS: cfg_ff.stuck_ticks <= csr_wdata[19:0];
            CSR_MASK_LOW: cfg_ff.mask_low <= csr_wdata;
            CSR_MASK_HIGH: cfg_ff.mask_high <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   i2cm_core u_core (
      .clock(clock),
      .reset(reset),
      .beat(beat),
      .req(req_data),
      .cfg(cfg_ff),
      .reply_cur(reply_cur),
      .rsp(core_rsp),
      .next_cmd_byte(next_cmd_byte)
   );

   i2cm_reply u_reply (
      .clock(clock),
      .reset(reset),
      .load(load),
      .rd_index(next_cmd_byte),
      .rd_data(reply_cur)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (beat) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (beat) rsp_data_ff <= core_rsp;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
endmodule
`default_nettype wire

>>> hdl/i2cm_reply.sv
// reply table with per-entry valid bits and a registered read
`default_nettype none
module i2cm_reply (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire i2cm_pkg::load_type load,
   input  wire logic [7:0]       rd_index,
   output logic [7:0]            rd_data
);
   import i2cm_pkg::*;

   logic [7:0] mem [REPLY_ENTRIES];
   logic [REPLY_ENTRIES-1:0] valid_ff;
   logic [7:0] mem_ff;
   logic [7:0] alt_ff;
   logic [7:0] alt_in;
   logic       use_mem_ff;
   logic       use_mem_in;
   logic       rd_range;
   logic       ld_range;
   logic [ReplyAw-1:0] rd_addr;
   logic [ReplyAw-1:0] ld_addr;

   function automatic logic [7:0] reset_value(input logic [ReplyAw-1:0] a);
      logic [7:0] v;
      v = BYTE_ONES;
      if (a == ReplyAw'(0)) v = 8'h05;
      if (a == ReplyAw'(1)) v = 8'h01;
      return v;
   endfunction

   assign rd_range = (9'(rd_index) < 9'(REPLY_ENTRIES));
   assign ld_range = (9'(load.index) < 9'(REPLY_ENTRIES));
   assign rd_addr = rd_index[ReplyAw-1:0];
   assign ld_addr = load.index[ReplyAw-1:0];

   always_comb begin
      alt_in = BYTE_ONES;
      use_mem_in = 1'b0;
      if (rd_range) begin
         if (load.load && ld_range && ld_addr == rd_addr) begin
            alt_in = load.value;
         end else if (valid_ff[rd_addr]) begin
            use_mem_in = 1'b1;
         end else begin
            alt_in = reset_value(rd_addr);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load.load && ld_range) begin
         mem[ld_addr] <= load.value;
      end
      mem_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         alt_ff <= 8'h05;
         use_mem_ff <= 1'b0;
      end else begin
         if (load.load && ld_range) valid_ff[ld_addr] <= 1'b1;
         alt_ff <= alt_in;
         use_mem_ff <= use_mem_in;
      end
   end

   assign rd_data = use_mem_ff ? mem_ff : alt_ff;
endmodule
`default_nettype wire

>>> hdl/i2cm_core.sv
// register file, bus state machine, countdowns and watchdog
`default_nettype none
module i2cm_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              beat,
   input  wire i2cm_pkg::req_type req,
   input  wire i2cm_pkg::cfg_type cfg,
   input  wire logic [7:0]        reply_cur,
   output i2cm_pkg::rsp_type      rsp,
   output logic [7:0]             next_cmd_byte
);
   import i2cm_pkg::*;

   typedef struct packed {
      logic [7:0]  cr;
      logic [7:0]  ic;
      logic [4:0]  live;
      logic        address_taken;
      logic        slave_addressed;
      logic        read_transfer;
      logic        rx_held;
      logic        stop_deferred;
      logic        arm_wait;
      logic        lines_muted;
      logic        touched;
      logic [7:0]  last_cmd;
      logic [15:0] byte_cd;
      logic [26:0] guard_cd;
      logic [26:0] mute_period;
   } st_type;

   localparam int CR_ICE = 7;
   localparam int CR_TRS = 4;
   localparam int CR_BBSY = 2;
   localparam int CR_SCP = 0;
   localparam int S_BUSY = 4;
   localparam int S_AL = 3;
   localparam int S_TACK = 2;
   localparam int S_WAIT = 1;
   localparam int S_DTE = 0;

   st_type st_ff, st_in;
   logic [7:0] regs_ff [REG_SPACE];
   logic [7:0] rd;

   function automatic st_type reset_state();
      st_type r;
      r = '0;
      r.mute_period = 27'd50000;
      return r;
   endfunction

   function automatic logic [26:0] deadline(input cfg_type c);
      return (c.stuck_ticks == 20'd0) ? 27'd1 : 27'(c.stuck_ticks);
   endfunction

   function automatic st_type byte_done(input st_type s, input cfg_type c);
      st_type r;
      r = s;
      if (r.cr[CR_ICE] && r.live[S_BUSY]) begin
         if (r.read_transfer && r.slave_addressed && !r.cr[CR_TRS]) begin
            r.rx_held = 1'b1;
            r.live[S_DTE] = 1'b1;
            if (r.ic[S_WAIT]) r.live[S_WAIT] = 1'b1;
         end else if (r.arm_wait && r.ic[S_WAIT]) begin
            r.live[S_WAIT] = 1'b1;
         end else begin
            r.live[S_DTE] = 1'b1;
         end
         r.touched = 1'b0;
         r.lines_muted = 1'b0;
         r.mute_period = deadline(c);
         r.guard_cd = deadline(c);
      end
      return r;
   endfunction

   function automatic st_type start_byte(input st_type s, input cfg_type c, input logic via);
      st_type r;
      r = s;
      r.arm_wait = via;
      if (c.byte_ticks == 16'd0) r = byte_done(r, c);
      else r.byte_cd = c.byte_ticks;
      return r;
   endfunction

   function automatic st_type end_transfer(input st_type s);
      st_type r;
      r = s;
      r.live[S_BUSY] = 1'b0;
      r.live[S_DTE] = 1'b0;
      r.live[S_WAIT] = 1'b0;
      r.address_taken = 1'b0;
      r.slave_addressed = 1'b0;
      r.read_transfer = 1'b0;
      r.rx_held = 1'b0;
      r.stop_deferred = 1'b0;
      r.byte_cd = '0;
      r.guard_cd = '0;
      return r;
   endfunction

   function automatic st_type watchdog(input st_type s, input cfg_type c);
      st_type r;
      r = s;
      if (!(r.live[S_DTE] || r.live[S_WAIT]) || r.touched) begin
         r.lines_muted = 1'b0;
      end else if (c.stuck_drop) begin
         r.live[S_DTE] = 1'b0;
         r.live[S_WAIT] = 1'b0;
      end else if (!r.lines_muted) begin
         r.lines_muted = 1'b1;
         r.guard_cd = r.mute_period;
         if (r.mute_period < (deadline(c) << MUTE_CAP_SHIFT))
            r.mute_period = {r.mute_period[25:0], 1'b0};
      end else begin
         r.lines_muted = 1'b0;
         r.guard_cd = deadline(c);
      end
      return r;
   endfunction

   function automatic st_type send_byte(input st_type s, input cfg_type c, input logic [7:0] v);
      st_type r;
      logic [6:0] a7;
      logic hit;
      r = s;
      a7 = v[7:1] & ADDR7_MASK;
      hit = a7[6] ? c.mask_high[a7[5:0]] : c.mask_low[a7[5:0]];
      r.live[S_DTE] = 1'b0;
      if (!r.address_taken) begin
         r.address_taken = 1'b1;
         r.slave_addressed = hit;
         r.read_transfer = v[0];
         if (!hit) begin
            if (c.nak_unanswered) r.live[S_TACK] = 1'b1;
            r.live[S_BUSY] = 1'b0;
            r.live[S_WAIT] = 1'b0;
            r.address_taken = 1'b0;
            r.byte_cd = '0;
            return r;
         end
      end else begin
         r.last_cmd = v;
      end
      return start_byte(r, c, 1'b1);
   endfunction

   function automatic st_type write_control(input st_type s, input cfg_type c,
                                            input logic [7:0] v);
      st_type r;
      logic [7:0] old;
      r = s;
      old = r.cr;
      r.touched = 1'b1;
      r.cr = v;
      if (!v[CR_ICE]) begin
         r.live = '0;
         return end_transfer(r);
      end
      if (old[CR_TRS] != v[CR_TRS]) begin
         r.live[S_DTE] = 1'b0;
         if (r.live[S_BUSY] && !v[CR_TRS]) r = start_byte(r, c, 1'b1);
      end
      if (!v[CR_SCP]) begin
         if (v[CR_BBSY]) begin
            r.live[S_BUSY] = 1'b1;
            r.live[S_DTE] = 1'b0;
            r.address_taken = 1'b0;
            r.slave_addressed = 1'b0;
            r = start_byte(r, c, 1'b0);
         end else if (r.read_transfer && r.rx_held) begin
            r.stop_deferred = 1'b1;
         end else if (r.live[S_BUSY]) begin
            r = end_transfer(r);
         end
      end
      return r;
   endfunction

   always_comb begin
      logic bus_fire;
      logic guard_fire;
      logic was_wait;
      st_in = st_ff;
      rd = 8'd0;
      bus_fire = 1'b0;
      guard_fire = 1'b0;
      was_wait = st_ff.live[S_WAIT];
      if (beat) begin
         case (req.cmd)
            CMD_READ: begin
               if (!cfg.slave_enable) begin
                  if (req.reg_offset == OFF_SR) rd = SR_FIXED;
                  else if (req.reg_offset == OFF_DR) rd = 8'd0;
                  else if (req.reg_offset == OFF_CR) rd = st_ff.cr;
                  else if (req.reg_offset == OFF_IC) rd = st_ff.ic;
                  else rd = regs_ff[req.reg_offset];
               end else if (req.reg_offset == OFF_SR) begin
                  rd = SR_FIXED | {3'd0, st_ff.live[S_BUSY], st_ff.live[S_AL],
                     st_ff.live[S_TACK] & st_ff.ic[S_TACK],
                     st_ff.live[S_WAIT] & st_ff.ic[S_WAIT], st_ff.live[S_DTE]};
               end else if (req.reg_offset == OFF_DR) begin
                  st_in.touched = 1'b1;
                  if (!st_ff.live[S_BUSY] || st_ff.cr[CR_TRS]) begin
                     rd = BYTE_ONES;
                  end else begin
                     rd = reply_cur;
                     st_in.live[S_DTE] = 1'b0;
                     st_in.rx_held = 1'b0;
                     if (st_ff.stop_deferred) st_in = end_transfer(st_in);
                     else st_in = start_byte(st_in, cfg, 1'b1);
                  end
               end else if (req.reg_offset == OFF_CR) begin
                  rd = st_ff.cr | 8'h01;
               end else if (req.reg_offset == OFF_IC) begin
                  rd = st_ff.ic;
               end else begin
                  rd = regs_ff[req.reg_offset];
               end
            end
            CMD_WRITE: begin
               if (!cfg.slave_enable) begin
                  if (req.reg_offset == OFF_CR) st_in.cr = req.write_data;
                  if (req.reg_offset == OFF_IC) st_in.ic = req.write_data;
               end else if (req.reg_offset == OFF_DR) begin
                  st_in.touched = 1'b1;
                  if (st_ff.live[S_BUSY] && st_ff.cr[CR_TRS])
                     st_in = send_byte(st_in, cfg, req.write_data);
               end else if (req.reg_offset == OFF_CR) begin
                  st_in = write_control(st_in, cfg, req.write_data);
               end else if (req.reg_offset == OFF_SR) begin
                  st_in.live[S_AL] = st_ff.live[S_AL] & req.write_data[S_AL];
                  st_in.live[S_TACK] = st_ff.live[S_TACK] & req.write_data[S_TACK];
                  st_in.live[S_WAIT] = st_ff.live[S_WAIT] & req.write_data[S_WAIT];
                  if (was_wait && !st_in.live[S_WAIT] && st_in.live[S_BUSY] && !st_in.rx_held)
                     st_in = start_byte(st_in, cfg, 1'b0);
               end else if (req.reg_offset == OFF_IC) begin
                  st_in.ic = req.write_data & IC_MASK;
               end
            end
            CMD_TICK: begin
               if (cfg.slave_enable) begin
                  if (st_ff.byte_cd != '0) begin
                     st_in.byte_cd = st_ff.byte_cd - 16'd1;
                     bus_fire = (st_in.byte_cd == '0);
                  end
                  if (st_ff.guard_cd != '0) begin
                     st_in.guard_cd = st_ff.guard_cd - 27'd1;
                     guard_fire = (st_in.guard_cd == '0);
                  end
                  if (guard_fire) st_in = watchdog(st_in, cfg);
                  if (bus_fire) st_in = byte_done(st_in, cfg);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= reset_state();
         for (int i = 0; i < REG_SPACE; i++) regs_ff[i] <= 8'd0;
      end else begin
         st_ff <= st_in;
         if (beat && req.cmd == CMD_WRITE) regs_ff[req.reg_offset] <= req.write_data;
      end
   end

   assign next_cmd_byte = st_in.last_cmd;

   always_comb begin
      rsp.read_data = rd;
      rsp.irq_arb_lost = cfg.slave_enable & st_in.live[S_AL] & st_in.ic[S_AL];
      rsp.irq_tack = cfg.slave_enable & st_in.live[S_TACK] & st_in.ic[S_TACK];
      rsp.irq_wait = cfg.slave_enable & st_in.live[S_WAIT] & st_in.ic[S_WAIT]
         & ~st_in.lines_muted;
      rsp.irq_dte = cfg.slave_enable & st_in.live[S_DTE] & st_in.ic[S_DTE]
         & ~st_in.lines_muted;
   end
endmodule
`default_nettype wire

>>> hdl/i2cm_checker.sv
// port-level checks for the i2c master register block, bound to the top
`default_nettype none
module i2cm_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire i2cm_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire i2cm_pkg::rsp_type rsp_data
);
   import i2cm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   a_non_read_zero: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.cmd != CMD_READ
      |=> rsp_valid && rsp_data.read_data == 8'd0)
      else $error("non-read beat returned data");
endmodule

bind i2c_master_with_answering_slaves i2cm_checker u_i2cm_checker (.*);
`default_nettype wire

>>> test/i2c_master_checker.sv
// checker: predicts every response beat of the i2c master block and compares it
`timescale 1ns / 1ps
module i2c_master_checker
   import i2cm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire req_type     req_data,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire rsp_type     rsp_data,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata,
   output int unsigned      mismatches
);
   localparam logic [7:0] CR_ICE = 8'h80;
   localparam logic [7:0] CR_TRS = 8'h10;
   localparam logic [7:0] CR_BBSY = 8'h04;
   localparam logic [7:0] CR_SCP = 8'h01;
   localparam logic [4:0] ST_BUSY = 5'h10;
   localparam logic [4:0] ST_AL = 5'h08;
   localparam logic [4:0] ST_TACK = 5'h04;
   localparam logic [4:0] ST_WAIT = 5'h02;
   localparam logic [4:0] ST_DTE = 5'h01;
   localparam logic [4:0] ST_WCLR = 5'h0E;
   localparam logic [7:0] IE_AL = 8'h08;
   localparam logic [7:0] IE_TACK = 8'h04;
   localparam logic [7:0] IE_WAIT = 8'h02;
   localparam logic [7:0] IE_DTE = 8'h01;

   logic        bus_on, nack_on, drop_on;
   logic [15:0] bticks;
   logic [19:0] sticks;
   logic [63:0] mask_lo, mask_hi;

   logic [7:0]  regs [REG_SPACE];
   logic [4:0]  status;
   bit          addr_taken, addressed, rd_xfer, rx_held, stop_pend;
   bit          wait_arm, muted, touched;
   logic [7:0]  last_cmd;
   logic [16:0] byte_cd;
   logic [26:0] guard_cd, mute_per;
   logic [7:0]  replies [REPLY_ENTRIES];

   rsp_type     pending_rsp [$];

   function automatic logic [26:0] deadline();
      return (sticks == 0) ? 27'd1 : 27'(sticks);
   endfunction

   function automatic bit answers(logic [6:0] a7);
      return a7[6] ? mask_hi[a7[5:0]] : mask_lo[a7[5:0]];
   endfunction

   function automatic void arm_guard();
      touched = 0;
      muted = 0;
      mute_per = deadline();
      guard_cd = deadline();
   endfunction

   function automatic void finish_byte();
      logic [7:0] cr, ic;
      cr = regs[OFF_CR];
      ic = regs[OFF_IC];
      if ((cr & CR_ICE) == 0 || (status & ST_BUSY) == 0) return;
      if (rd_xfer && addressed && (cr & CR_TRS) == 0) begin
         rx_held = 1;
         status |= ST_DTE;
         if (ic & IE_WAIT) status |= ST_WAIT;
      end else if (wait_arm && (ic & IE_WAIT)) begin
         status |= ST_WAIT;
      end else begin
         status |= ST_DTE;
      end
      arm_guard();
   endfunction

   function automatic void begin_byte(bit w);
      wait_arm = w;
      if (bticks == 0) finish_byte();
      else byte_cd = 17'(bticks);
   endfunction

   function automatic void watchdog();
      if ((status & (ST_DTE | ST_WAIT)) == 0 || touched) begin
         muted = 0;
         return;
      end
      if (drop_on) begin
         status &= ~(ST_DTE | ST_WAIT);
         return;
      end
      if (!muted) begin
         muted = 1;
         guard_cd = mute_per;
         if (32'(mute_per) < 32'(deadline()) * 64) mute_per = mute_per << 1;
         return;
      end
      muted = 0;
      guard_cd = deadline();
   endfunction

   function automatic void end_xfer();
      status &= ~(ST_BUSY | ST_DTE | ST_WAIT);
      addr_taken = 0;
      addressed = 0;
      rd_xfer = 0;
      rx_held = 0;
      stop_pend = 0;
      byte_cd = 0;
      guard_cd = 0;
   endfunction

   function automatic void send_data(logic [7:0] v);
      status &= ~ST_DTE;
      if (!addr_taken) begin
         addr_taken = 1;
         addressed = answers(v[7:1]);
         rd_xfer = v[0];
         if (!addressed) begin
            if (nack_on) status |= ST_TACK;
            status &= ~(ST_BUSY | ST_DTE | ST_WAIT);
            addr_taken = 0;
            byte_cd = 0;
            return;
         end
      end else begin
         last_cmd = v;
      end
      begin_byte(1);
   endfunction

   function automatic logic [7:0] recv_data();
      logic [7:0] v;
      if ((status & ST_BUSY) == 0 || (regs[OFF_CR] & CR_TRS) != 0) return BYTE_ONES;
      v = (int'(last_cmd) < REPLY_ENTRIES) ? replies[last_cmd] : BYTE_ONES;
      status &= ~ST_DTE;
      rx_held = 0;
      if (stop_pend) end_xfer();
      else begin_byte(1);
      return v;
   endfunction

   function automatic void write_cr(logic [7:0] v);
      logic [7:0] old;
      old = regs[OFF_CR];
      touched = 1;
      regs[OFF_CR] = v;
      if ((v & CR_ICE) == 0) begin
         status = 0;
         end_xfer();
         return;
      end
      if ((old ^ v) & CR_TRS) begin
         status &= ~ST_DTE;
         if ((status & ST_BUSY) != 0 && (v & CR_TRS) == 0) begin_byte(1);
      end
      if ((v & CR_SCP) == 0) begin
         if (v & CR_BBSY) begin
            status |= ST_BUSY;
            status &= ~ST_DTE;
            addr_taken = 0;
            addressed = 0;
            begin_byte(0);
         end else if (rd_xfer && rx_held) begin
            stop_pend = 1;
         end else if (status & ST_BUSY) begin
            end_xfer();
         end
      end
   endfunction

   function automatic void write_sr(logic [7:0] v);
      logic [4:0] was;
      was = status;
      status &= (v[4:0] | ~ST_WCLR);
      if ((was & ST_WAIT) != 0 && (status & ST_WAIT) == 0 &&
          (status & ST_BUSY) != 0 && !rx_held)
         begin_byte(0);
   endfunction

   function automatic logic [7:0] read_reg(logic [4:0] idx);
      logic [7:0] v;
      if (!bus_on) begin
         if (idx == OFF_SR) return SR_FIXED;
         if (idx == OFF_DR) return 8'h00;
         return regs[idx];
      end
      if (idx == OFF_SR) begin
         v = SR_FIXED | 8'(status & (ST_BUSY | ST_AL | ST_DTE));
         if (regs[OFF_IC] & IE_TACK) v |= 8'(status & ST_TACK);
         if (regs[OFF_IC] & IE_WAIT) v |= 8'(status & ST_WAIT);
         return v;
      end
      if (idx == OFF_DR) begin
         touched = 1;
         return recv_data();
      end
      if (idx == OFF_CR) return regs[idx] | CR_SCP;
      return regs[idx];
   endfunction

   function automatic void write_reg(logic [4:0] idx, logic [7:0] v);
      if (!bus_on) begin
         regs[idx] = v;
         return;
      end
      case (idx)
         OFF_DR: begin
            touched = 1;
            regs[idx] = v;
            if ((status & ST_BUSY) != 0 && (regs[OFF_CR] & CR_TRS) != 0) send_data(v);
         end
         OFF_CR: write_cr(v);
         OFF_SR: write_sr(v);
         OFF_IC: regs[idx] = v & IC_MASK;
         default: regs[idx] = v;
      endcase
   endfunction

   function automatic void tick_once();
      bit bus_fire, guard_fire;
      bus_fire = 0;
      guard_fire = 0;
      if (!bus_on) return;
      if (byte_cd != 0) begin
         byte_cd--;
         bus_fire = (byte_cd == 0);
      end
      if (guard_cd != 0) begin
         guard_cd--;
         guard_fire = (guard_cd == 0);
      end
      if (guard_fire) watchdog();
      if (bus_fire) finish_byte();
   endfunction

   function automatic rsp_type predict_rsp(req_type r);
      rsp_type o;
      logic [7:0] ic;
      o = '0;
      case (r.cmd)
         CMD_READ: o.read_data = read_reg(r.reg_offset);
         CMD_WRITE: write_reg(r.reg_offset, r.write_data);
         CMD_TICK: tick_once();
         default: if (int'(r.reply_index) < REPLY_ENTRIES) replies[r.reply_index] = r.reply_value;
      endcase
      ic = regs[OFF_IC];
      if (bus_on) begin
         o.irq_arb_lost = (status & ST_AL) != 0 && (ic & IE_AL) != 0;
         o.irq_tack = (status & ST_TACK) != 0 && (ic & IE_TACK) != 0;
         o.irq_wait = (status & ST_WAIT) != 0 && (ic & IE_WAIT) != 0 && !muted;
         o.irq_dte = (status & ST_DTE) != 0 && (ic & IE_DTE) != 0 && !muted;
      end
      return o;
   endfunction

   function automatic void reset_model();
      bus_on = 0;
      nack_on = 0;
      drop_on = 0;
      bticks = 16'd90;
      sticks = 20'd50000;
      mask_lo = 64'h0001_0000_0000_0000;
      mask_hi = '0;
      foreach (regs[i]) regs[i] = '0;
      status = 0;
      addr_taken = 0;
      addressed = 0;
      rd_xfer = 0;
      rx_held = 0;
      stop_pend = 0;
      wait_arm = 0;
      muted = 0;
      touched = 0;
      last_cmd = 0;
      byte_cd = 0;
      guard_cd = 0;
      mute_per = 27'(sticks);
      foreach (replies[i]) replies[i] = BYTE_ONES;
      replies[0] = 8'h05;
      replies[1] = 8'h01;
      pending_rsp.delete();
   endfunction

   initial mismatches = 0;

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         reset_model();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_SLAVE_ENABLE: bus_on = csr_wdata[0];
               CSR_NAK_UNANSWERED: nack_on = csr_wdata[0];
               CSR_STUCK_DROP: drop_on = csr_wdata[0];
               CSR_BYTE_TICKS: bticks = csr_wdata[15:0];
               CSR_STUCK_TICKS: sticks = csr_wdata[19:0];
               CSR_MASK_LOW: mask_lo = csr_wdata;
               CSR_MASK_HIGH: mask_hi = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) pending_rsp.push_back(predict_rsp(req_data));
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $error("response beat with nothing expected: %h", rsp_data);
               mismatches++;
            end else begin
               exp_rsp = pending_rsp.pop_front();
               if (rsp_data.read_data !== exp_rsp.read_data) begin
                  $error("read_data expected %h actual %h", exp_rsp.read_data,
                         rsp_data.read_data);
                  mismatches++;
               end
               if (rsp_data.irq_arb_lost !== exp_rsp.irq_arb_lost) begin
                  $error("irq_arb_lost expected %b actual %b", exp_rsp.irq_arb_lost,
                         rsp_data.irq_arb_lost);
                  mismatches++;
               end
               if (rsp_data.irq_tack !== exp_rsp.irq_tack) begin
                  $error("irq_tack expected %b actual %b", exp_rsp.irq_tack,
                         rsp_data.irq_tack);
                  mismatches++;
               end
               if (rsp_data.irq_wait !== exp_rsp.irq_wait) begin
                  $error("irq_wait expected %b actual %b", exp_rsp.irq_wait,
                         rsp_data.irq_wait);
                  mismatches++;
               end
               if (rsp_data.irq_dte !== exp_rsp.irq_dte) begin
                  $error("irq_dte expected %b actual %b", exp_rsp.irq_dte,
                         rsp_data.irq_dte);
                  mismatches++;
               end
            end
         end
      end
   end
endmodule

>>> test/tb_i2c_master_with_answering_slaves.sv
// testbench top: drives register, tick and table beats through the i2c master
`timescale 1ns / 1ps
module tb_i2c_master_with_answering_slaves;
   import i2cm_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   rsp_type     rsp_data;
   logic        csr_write = 0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;
   int unsigned mismatches;

   bit          idle_on;
   int unsigned beats_sent, beats_back, cycles;
   logic [15:0] cur_bt;
   logic [63:0] cur_lo, cur_hi;

   i2c_master_with_answering_slaves dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_write, .csr_index, .csr_wdata
   );

   i2c_master_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_write, .csr_index, .csr_wdata,
      .mismatches
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= !idle_on || ($urandom_range(99) >= 38);
      if (!reset && rsp_valid && rsp_ready) beats_back <= beats_back + 1;
   end

   task automatic send(req_type r);
      while (idle_on && $urandom_range(99) < 38) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   function automatic req_type mk(logic [1:0] c, logic [4:0] off, logic [7:0] d);
      req_type r;
      r.cmd = c;
      r.reg_offset = off;
      r.write_data = d;
      r.reply_index = 8'($urandom);
      r.reply_value = 8'($urandom);
      return r;
   endfunction

   task automatic wr(logic [4:0] off, logic [7:0] d);
      send(mk(CMD_WRITE, off, d));
   endtask

   task automatic rd(logic [4:0] off);
      send(mk(CMD_READ, off, 8'($urandom)));
   endtask

   task automatic ticks(int n);
      repeat (n) send(mk(CMD_TICK, 5'($urandom), 8'($urandom)));
   endtask

   task automatic load(logic [7:0] idx, logic [7:0] v);
      req_type r;
      r = mk(CMD_LOAD, 5'($urandom), 8'($urandom));
      r.reply_index = idx;
      r.reply_value = v;
      send(r);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (beats_back != beats_sent) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr(logic [2:0] idx, logic [63:0] v);
      csr_write <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_write <= 0;
   endtask

   function automatic int byte_wait();
      return (cur_bt > 6) ? $urandom_range(1, 6) : int'(cur_bt) + $urandom_range(2);
   endfunction

   function automatic logic [6:0] pick_addr();
      logic [6:0] a;
      a = 7'($urandom);
      if ($urandom_range(9) < 8)
         repeat (16) if (!(a[6] ? cur_hi[a[5:0]] : cur_lo[a[5:0]])) a = 7'($urandom);
      return a & ADDR7_MASK;
   endfunction

   // start, address, command bytes, then either a stop or a read-back
   task automatic transfer();
      logic [6:0] a7;
      int n;
      a7 = pick_addr();
      wr(OFF_IC, ($urandom_range(3) == 0) ? 8'($urandom) : IC_MASK);
      wr(OFF_CR, 8'h94);
      ticks(byte_wait());
      wr(OFF_DR, {a7, 1'b0});
      ticks(byte_wait());
      n = $urandom_range(1, 3);
      repeat (n) begin
         wr(OFF_DR, 8'($urandom_range(3) == 0 ? $urandom_range(3) : $urandom));
         ticks(byte_wait());
         rd(OFF_SR);
         if ($urandom_range(1)) wr(OFF_SR, 8'hFD);
      end
      if ($urandom_range(1)) begin
         wr(OFF_CR, 8'h94);
         ticks(byte_wait());
         wr(OFF_DR, {a7, 1'b1});
         ticks(byte_wait());
         wr(OFF_CR, 8'h81);
         repeat ($urandom_range(1, 3)) begin
            ticks(byte_wait());
            rd(OFF_DR);
         end
         ticks(byte_wait());
         wr(OFF_CR, 8'h80);
         rd(OFF_DR);
         rd(OFF_SR);
      end else begin
         if ($urandom_range(3) == 0) ticks($urandom_range(1, 40));
         wr(OFF_CR, 8'h90);
      end
   endtask

   task automatic noise();
      logic [4:0] off;
      logic [1:0] c;
      repeat ($urandom_range(1, 6)) begin
         c = 2'($urandom);
         off = ($urandom_range(1)) ? 5'($urandom) : 5'($urandom_range(3) * 4);
         if (c == CMD_TICK && $urandom_range(3) == 0) ticks($urandom_range(1, 30));
         else send(mk(c, off, 8'($urandom)));
      end
   endtask

   task automatic phase(bit en, bit nack, bit drop, logic [15:0] bt, logic [19:0] stk,
                        logic [63:0] lo, logic [63:0] hi, int budget, bit idles);
      int unsigned stop_at;
      drain();
      csr(CSR_SLAVE_ENABLE, 64'(en));
      csr(CSR_NAK_UNANSWERED, 64'(nack));
      csr(CSR_STUCK_DROP, 64'(drop));
      csr(CSR_BYTE_TICKS, 64'(bt));
      csr(CSR_STUCK_TICKS, 64'(stk));
      csr(CSR_MASK_LOW, lo);
      csr(CSR_MASK_HIGH, hi);
      cur_bt = bt;
      cur_lo = lo;
      cur_hi = hi;
      idle_on = idles;
      stop_at = beats_sent + budget;
      while (beats_sent < stop_at) begin
         if ($urandom_range(9) < 6) transfer();
         else noise();
      end
   endtask

   initial begin
      cycles = 0;
      beats_sent = 0;
      beats_back = 0;
      idle_on = 1;
      cur_bt = 16'd90;
      cur_lo = 64'h0001_0000_0000_0000;
      cur_hi = '0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: disabled storage, table edges, then the bus with defaults
      rd(OFF_SR);
      rd(OFF_DR);
      wr(5'd31, 8'hFF);
      rd(5'd31);
      wr(OFF_CR, 8'h00);
      rd(OFF_CR);
      ticks(2);
      load(8'd0, 8'h00);
      load(8'd255, 8'hA5);
      drain();
      csr(CSR_SLAVE_ENABLE, 64'd1);
      wr(OFF_IC, 8'hFF);
      rd(OFF_IC);
      rd(OFF_DR);
      rd(OFF_CR);
      wr(OFF_SR, 8'h00);
      wr(OFF_CR, 8'h94);
      ticks(3);
      wr(OFF_DR, 8'hFF);
      wr(OFF_DR, {7'd48, 1'b0});
      wr(OFF_DR, 8'd255);
      rd(OFF_SR);
      wr(OFF_SR, 8'hF1);
      wr(OFF_CR, 8'h90);
      rd(OFF_SR);

      phase(1, 0, 0, 16'd0, 20'd1, '1, '1, 200, 0);
      phase(1, 1, 0, 16'd2, 20'd5, {$urandom, $urandom}, {$urandom, $urandom}, 200, 1);
      phase(1, 1, 1, 16'd1, 20'd3, 64'h0001_0000_0000_0000, '0, 180, 1);
      phase(1, 0, 0, 16'd65535, 20'hFFFFF, {$urandom, $urandom}, {$urandom, $urandom},
            100, 1);
      phase(0, 1, 1, 16'd3, 20'd2, '0, '0, 150, 1);
      phase(1, 1, 0, 16'd3, 20'd20, '0, '0, 150, 1);
      phase(1, 0, 1, 16'd0, 20'd0, '1, '0, 180, 1);
      phase(1, 0, 0, 16'd4, 20'd1, {$urandom, $urandom}, '1, 200, 1);
      phase(1, 1, 0, 16'd1, 20'd2, '1, {$urandom, $urandom}, 150, 1);

      drain();
      repeat (4) @(posedge clock);
      if (mismatches == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule

>>> sim.f
hdl/i2cm_pkg.sv
hdl/i2cm_reply.sv
hdl/i2cm_core.sv
hdl/i2c_master_with_answering_slaves.sv
hdl/i2cm_checker.sv
test/i2c_master_checker.sv
test/tb_i2c_master_with_answering_slaves.sv
